// ===== hdl/frt_pkg.sv =====
// ---------------------------------------------------------------------------
// frt_pkg
// shared types and constants of the fragment reassembly table
// ---------------------------------------------------------------------------
package frt_pkg;

  localparam int PAYLOAD_BYTES   = 16;
  localparam int MAX_FRAGMENTS   = 4;
  localparam int SIGNATURE_COUNT = 256;

  localparam int SIG_W  = 8;
  localparam int POS_W  = 2;
  localparam int BYTE_W = 4;
  localparam int SLOT_W = SIG_W + POS_W;
  localparam int ADDR_W = SLOT_W + BYTE_W;
  localparam int TOT_W  = 3;
  localparam int FILL_W = 5;

  typedef enum logic [1:0] {
    KIND_FRAG = 2'd0,
    KIND_TICK = 2'd1,
    KIND_POLL = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_EMPTY    = 2'd0,
    RES_BYTE     = 2'd1,
    RES_CONFLICT = 2'd2
  } res_kind_t;

  // one input item, as queued between front and back
  typedef struct packed {
    kind_t             kind;
    logic [SIG_W-1:0]  sig;
    logic [TOT_W-1:0]  total;
    logic [POS_W-1:0]  pos;
    logic [4:0]        len;
    logic [BYTE_W-1:0] bi;
    logic [7:0]        data;
  } item_t;

  typedef struct packed {
    res_kind_t         kind;
    logic [SIG_W-1:0]  sig;
    logic [5:0]        off;
    logic [7:0]        data;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    ST_RESET,
    ST_IDLE,
    ST_FRAG_RD,
    ST_FRAG_WR,
    ST_FILL_CLR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MSG_RD,
    ST_MSG_OUT,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/frt_front.sv =====
// ---------------------------------------------------------------------------
// frt_front
// two-entry queue of classified items
// ---------------------------------------------------------------------------
module frt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  frt_pkg::item_t  in_item,
  output logic            q_valid,
  input  logic            q_take,
  output frt_pkg::item_t  q_item
);

  frt_pkg::item_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;
  logic           keep;

  // ticks are queued too so order is kept; unused kind 3 is accepted and dropped
  assign keep     = (in_item.kind != frt_pkg::KIND_NONE);
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_take) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take};
    end
  end

endmodule

// ===== hdl/frt_back.sv =====
// ---------------------------------------------------------------------------
// frt_back
// table sequencer: fragment update, tick count, poll scan and message streaming
// ---------------------------------------------------------------------------
module frt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             q_valid,
  output logic             q_take,
  input  frt_pkg::item_t   q_item,
  output logic             res_valid,
  input  logic             res_ready,
  output frt_pkg::result_t res
);

  localparam int SC = frt_pkg::SIGNATURE_COUNT;
  localparam int SW = frt_pkg::SIG_W;

  // valid bits and per-signature table in memories
  logic [SC-1:0]              valid_r;
  logic [frt_pkg::TOT_W-1:0]  rem_mem [SC];
  logic [frt_pkg::TOT_W-1:0]  tot_mem [SC];
  logic [31:0]                time_mem [SC];
  logic [frt_pkg::FILL_W-1:0] fill_mem [SC*frt_pkg::MAX_FRAGMENTS];
  logic [7:0]                 data_mem [SC*frt_pkg::MAX_FRAGMENTS*frt_pkg::PAYLOAD_BYTES];

  frt_pkg::state_t state_r, state_nxt;
  logic [15:0]     timeout_r;
  logic [31:0]     now_r, now_nxt;
  frt_pkg::item_t  it_r, it_nxt;
  logic [SW:0]     scan_r, scan_nxt;
  logic [5:0]      off_r, off_nxt;
  frt_pkg::result_t res_r, res_nxt;
  logic            res_valid_r, res_valid_nxt;

  // registered reads
  logic [frt_pkg::TOT_W-1:0]  rem_q, tot_q;
  logic [31:0]                time_q;
  logic [frt_pkg::FILL_W-1:0] fill_q;
  logic [7:0]                 data_q;

  // memory control
  logic                       tbl_we;
  logic [SW-1:0]              tbl_rd_a, tbl_wr_a;
  logic [frt_pkg::TOT_W-1:0]  rem_wd, tot_wd;
  logic                       tim_we, tot_we;
  logic                       fill_we;
  logic [frt_pkg::SLOT_W-1:0] fill_rd_a, fill_wr_a;
  logic [frt_pkg::FILL_W-1:0] fill_wd;
  logic                       data_we;
  logic [frt_pkg::ADDR_W-1:0] data_rd_a, data_wr_a;
  logic                       set_v, clr_v, clr_all;
  logic [SW-1:0]              v_a;

  logic [frt_pkg::TOT_W-1:0] tot_sat;
  logic                      ent_v;
  logic [frt_pkg::SLOT_W-1:0] slot;

  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign ent_v     = valid_r[it_r.sig];
  assign slot      = {it_r.sig, it_r.pos};

  always_comb begin
    tot_sat = it_r.total;
    if (tot_sat == '0) tot_sat = 3'd1;
    if (tot_sat > 3'(frt_pkg::MAX_FRAGMENTS)) tot_sat = 3'(frt_pkg::MAX_FRAGMENTS);
  end

  // table memories
  always_ff @(posedge clk) begin
    if (tbl_we) rem_mem[tbl_wr_a] <= rem_wd;
    if (tot_we) tot_mem[tbl_wr_a] <= tot_wd;
    if (tim_we) time_mem[tbl_wr_a] <= now_r;
    rem_q  <= rem_mem[tbl_rd_a];
    tot_q  <= tot_mem[tbl_rd_a];
    time_q <= time_mem[tbl_rd_a];
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wr_a] <= fill_wd;
    fill_q <= fill_mem[fill_rd_a];
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_wr_a] <= it_r.data;
    data_q <= data_mem[data_rd_a];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frt_pkg::ST_IDLE;
      timeout_r   <= 16'd1000;
      now_r       <= '0;
      valid_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_wr_en) timeout_r <= cfg_wr_data;
      if (clr_all) valid_r <= '0;
      else if (set_v) valid_r[v_a] <= 1'b1;
      else if (clr_v) valid_r[v_a] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    it_r   <= it_nxt;
    scan_r <= scan_nxt;
    off_r  <= off_nxt;
    res_r  <= res_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    it_nxt        = it_r;
    scan_nxt      = scan_r;
    off_nxt       = off_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    q_take        = 1'b0;
    tbl_we = 1'b0; tot_we = 1'b0; tim_we = 1'b0;
    tbl_rd_a = it_r.sig; tbl_wr_a = it_r.sig;
    rem_wd = rem_q - 3'd1; tot_wd = tot_sat;
    fill_we = 1'b0; fill_rd_a = slot; fill_wr_a = slot; fill_wd = '0;
    data_we = 1'b0; data_wr_a = {slot, it_r.bi};
    data_rd_a = {scan_r[SW-1:0], off_r};
    set_v = 1'b0; clr_v = 1'b0; clr_all = 1'b0; v_a = it_r.sig;
    case (state_r)
      frt_pkg::ST_IDLE: begin
        if (q_valid && !res_valid_nxt) begin
          q_take = 1'b1;
          it_nxt = q_item;
          case (q_item.kind)
            frt_pkg::KIND_FRAG: state_nxt = frt_pkg::ST_FRAG_RD;
            frt_pkg::KIND_TICK: now_nxt = now_r + 32'd1;
            frt_pkg::KIND_POLL: begin
              scan_nxt  = '0;
              state_nxt = frt_pkg::ST_SCAN_RD;
            end
            default: ;
          endcase
        end
      end
      frt_pkg::ST_FRAG_RD: begin
        // table and fill read issue in this cycle
        state_nxt = frt_pkg::ST_FRAG_WR;
      end
      frt_pkg::ST_FRAG_WR: begin
        state_nxt = frt_pkg::ST_IDLE;
        if (it_r.bi == '0 && !ent_v) begin
          set_v = 1'b1; tbl_we = 1'b1; tot_we = 1'b1; tim_we = 1'b1;
          rem_wd = tot_sat - 3'd1;
          off_nxt = '0;
          state_nxt = frt_pkg::ST_FILL_CLR;
        end else if (it_r.bi == '0 && rem_q == '0) begin
          clr_all = 1'b1;
          res_nxt = '{frt_pkg::RES_CONFLICT, it_r.sig, 6'd0, 8'd0, 1'b0};
          res_valid_nxt = 1'b1;
        end else begin
          if (it_r.bi == '0) tbl_we = 1'b1;
          if (ent_v && {1'b0, it_r.pos} < tot_q && {1'b0, it_r.bi} < it_r.len
              && {1'b0, it_r.bi} <= fill_q) begin
            data_we = 1'b1;
            if ({1'b0, it_r.bi} + 5'd1 > fill_q) begin
              fill_we = 1'b1;
              fill_wd = {1'b0, it_r.bi} + 5'd1;
            end
          end
        end
      end
      frt_pkg::ST_FILL_CLR: begin
        // clear the fill of each slot; the opening byte lands in its own slot
        fill_we   = 1'b1;
        fill_wr_a = {it_r.sig, off_r[frt_pkg::POS_W-1:0]};
        if (off_r[frt_pkg::POS_W-1:0] == it_r.pos && {1'b0, it_r.pos} < tot_sat
            && it_r.len != '0) begin
          fill_wd = 5'd1;
          data_we = 1'b1;
        end
        off_nxt   = off_r + 6'd1;
        if (off_r == 6'(frt_pkg::MAX_FRAGMENTS - 1)) begin
          state_nxt = frt_pkg::ST_IDLE;
        end
      end
      frt_pkg::ST_SCAN_RD: begin
        tbl_rd_a = scan_r[SW-1:0];
        if (scan_r == (SW+1)'(SC)) begin
          res_nxt = '{frt_pkg::RES_EMPTY, 8'd0, 6'd0, 8'd0, 1'b0};
          res_valid_nxt = 1'b1;
          state_nxt = frt_pkg::ST_EMIT;
        end else if (!valid_r[scan_r[SW-1:0]]) begin
          scan_nxt = scan_r + 1'b1;
        end else begin
          state_nxt = frt_pkg::ST_SCAN_CHK;
        end
      end
      frt_pkg::ST_SCAN_CHK: begin
        v_a = scan_r[SW-1:0];
        if (rem_q == '0) begin
          off_nxt   = '0;
          state_nxt = frt_pkg::ST_MSG_RD;
        end else begin
          if (now_r - time_q > {16'd0, timeout_r}) clr_v = 1'b1;
          scan_nxt  = scan_r + 1'b1;
          state_nxt = frt_pkg::ST_SCAN_RD;
        end
      end
      frt_pkg::ST_MSG_RD: begin
        // read total, fill and byte at off_r
        tbl_rd_a  = scan_r[SW-1:0];
        fill_rd_a = {scan_r[SW-1:0], off_r[5:4]};
        if (!res_valid_nxt) state_nxt = frt_pkg::ST_MSG_OUT;
      end
      frt_pkg::ST_MSG_OUT: begin
        res_nxt.kind = frt_pkg::RES_BYTE;
        res_nxt.sig  = scan_r[SW-1:0];
        res_nxt.off  = off_r;
        res_nxt.data = ({1'b0, off_r[3:0]} < fill_q) ? data_q : 8'd0;
        res_nxt.last = (off_r[5:4] + 2'd1 == tot_q[1:0] || (tot_q == 3'd4 && off_r[5:4] == 2'd3))
                       && off_r[3:0] == 4'hF;
        res_valid_nxt = 1'b1;
        off_nxt = off_r + 6'd1;
        v_a = scan_r[SW-1:0];
        if (res_nxt.last) begin
          clr_v = 1'b1;
          state_nxt = frt_pkg::ST_EMIT;
        end else begin
          state_nxt = frt_pkg::ST_MSG_RD;
        end
      end
      frt_pkg::ST_EMIT: begin
        if (!res_valid_nxt) state_nxt = frt_pkg::ST_IDLE;
      end
      default: state_nxt = frt_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/fragment_reassembly_table_top.sv =====
// ---------------------------------------------------------------------------
// fragment_reassembly_table_top
// reassembles fragmented messages into a signature-indexed table
// ---------------------------------------------------------------------------
// input stream: one transfer per fragment byte, tick or poll (tuser = kind)
// output stream: one transfer per result; a poll yields an empty result or
// every byte of the first complete message, tlast on its final byte
// a two-entry queue parts the input from the table sequencer
// a fragment byte takes a table read, then a read-modify-write; the opening
// byte of a new signature then clears the fill counts of its slots
// a tick advances the tick count; a poll scans signatures in order, checking
// each occupied one, then reads and outputs each byte of a complete message
// reset empties the table, sets timeout to 1000 and the tick count to 0
// when the receiver stalls, the held result blocks the sequencer and the
// queue fills, after which in_tready falls
// ---------------------------------------------------------------------------
module fragment_reassembly_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // frag_signature, frag_total, frag_position, frag_length, byte_index,
  // payload_byte, zero pad
  input  logic [31:0] in_tdata,
  // kind
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_signature, byte_offset, message_byte, zero pad
  output logic [23:0] out_tdata,
  // result_kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  frt_pkg::item_t   in_item, q_item;
  frt_pkg::result_t res;
  logic             q_valid, q_take;

  assign in_item.kind  = frt_pkg::kind_t'(in_tuser);
  assign in_item.sig   = in_tdata[7:0];
  assign in_item.total = in_tdata[10:8];
  assign in_item.pos   = in_tdata[12:11];
  assign in_item.len   = in_tdata[17:13];
  assign in_item.bi    = in_tdata[21:18];
  assign in_item.data  = in_tdata[29:22];

  frt_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_item(in_item),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  frt_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {2'b00, res.data, res.off, res.sig};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
